>>> rtl/cht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cht_pkg;

  // Widest table index the block supports (entries per half up to 2**20)
  localparam int IDX_MAX_W = 20;

  // Shared divider operand widths
  localparam int DIV_W  = 32;
  localparam int DVSR_W = 14;

  // Continuation index hash multiplier
  localparam logic [15:0] CKEY_MULT = 16'ha28f;

  // Configuration register indexes
  localparam logic [1:0] REG_GRAIN     = 2'd0;
  localparam logic [1:0] REG_DEPTH_DIV = 2'd1;
  localparam logic [1:0] REG_MAX_CORR  = 2'd2;

  // Reset values of the configuration registers
  localparam logic [10:0] GRAIN_RST     = 11'd256;
  localparam logic [10:0] DEPTH_DIV_RST = 11'd8;
  localparam logic [13:0] MAX_CORR_RST  = 14'd1024;

  // Request codes
  localparam logic MODE_PROBE  = 1'b0;
  localparam logic MODE_UPDATE = 1'b1;

  // Classified request handed from front to back
  typedef struct packed {
    logic                   mode;
    logic                   side;
    logic [IDX_MAX_W-1:0]   idx_pawn;
    logic [IDX_MAX_W-1:0]   idx_minor;
    logic [IDX_MAX_W-1:0]   idx_last;
    logic [IDX_MAX_W-1:0]   idx_cont;
    logic signed [15:0]     diff;
    logic [7:0]             depth;
  } cmd_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MOD,
    F_PUSH
  } front_state_e;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_ADDR,
    B_READ,
    B_LATCH,
    B_SUM,
    B_PDIV,
    B_OUT,
    B_MUL1,
    B_MUL2,
    B_SDIVST,
    B_SDIV,
    B_CLAMP,
    B_EMUL,
    B_EDIVST,
    B_EDIV
  } back_state_e;

endpackage
`default_nettype wire

>>> rtl/cht_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module cht_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32768
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

>>> rtl/cht_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module cht_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire cht_pkg::cmd_t wdata_i,
  input  wire logic          pop_i,
  output cht_pkg::cmd_t      rdata_o,
  output logic               full_o,
  output logic               empty_o
);
  import cht_pkg::*;

  cmd_t       slot_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = slot_q[rptr_q];

  // Store requests
  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i && !full_o) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i && !empty_o) begin
        rptr_q <= ~rptr_q;
      end
      case ({push_i && !full_o, pop_i && !empty_o})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/cht_front.sv
`timescale 1ns / 1ps
`default_nettype none
module cht_front #(
  parameter int TABLE_ENTRIES = 16384
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic          mode_i,
  input  wire logic [63:0]   pawn_key_i,
  input  wire logic [63:0]   minor_key_i,
  input  wire logic [15:0]   last_move_i,
  input  wire logic [15:0]   cont_move_i,
  input  wire logic          side_i,
  input  wire logic [15:0]   diff_i,
  input  wire logic [7:0]    depth_i,
  input  wire logic          q_full_i,
  output logic               push_o,
  output cht_pkg::cmd_t      cmd_o,
  output logic               busy_o
);
  import cht_pkg::*;

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int TW = IW + 4;

  front_state_e state_q, state_d;

  logic [63:0]        pk_q, mk_q;
  logic [15:0]        last_q, ckey_q;
  logic               mode_q, side_q;
  logic signed [15:0] diff_q;
  logic [7:0]         depth_q;
  logic [3:0]         nib_q;
  logic [IW-1:0]      rem_q [4];
  logic [IW-1:0]      rem_d [4];
  logic [3:0]         in_nib [4];
  logic [31:0]        hash_w;

  // Continuation hash on the accepted request
  assign hash_w = {16'd0, last_move_i} * {16'd0, CKEY_MULT};

  // Current key nibbles, short keys zero-extended
  always_comb begin
    in_nib[0] = pk_q[{nib_q, 2'b00} +: 4];
    in_nib[1] = mk_q[{nib_q, 2'b00} +: 4];
    in_nib[2] = (nib_q[3:2] == 2'd0) ? last_q[{nib_q[1:0], 2'b00} +: 4] : 4'd0;
    in_nib[3] = (nib_q[3:2] == 2'd0) ? ckey_q[{nib_q[1:0], 2'b00} +: 4] : 4'd0;
  end

  // One radix-16 remainder step per lane: drop the largest multiple that fits
  always_comb begin
    logic [TW-1:0] t;
    logic [TW-1:0] sub;
    for (int i = 0; i < 4; i++) begin
      t   = {rem_q[i], in_nib[i]};
      sub = '0;
      for (int j = 1; j < 16; j++) begin
        if (t >= TW'(j * TABLE_ENTRIES)) begin
          sub = TW'(j * TABLE_ENTRIES);
        end
      end
      rem_d[i] = IW'(t - sub);
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: if (accept_i) state_d = F_MOD;
      F_MOD:  if (nib_q == 4'd0) state_d = F_PUSH;
      F_PUSH: if (!q_full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy_o = (state_q != F_IDLE);
    push_o = (state_q == F_PUSH) && !q_full_i;
    cmd_o.mode      = mode_q;
    cmd_o.side      = side_q;
    cmd_o.idx_pawn  = IDX_MAX_W'(rem_q[0]);
    cmd_o.idx_minor = IDX_MAX_W'(rem_q[1]);
    cmd_o.idx_last  = IDX_MAX_W'(rem_q[2]);
    cmd_o.idx_cont  = IDX_MAX_W'(rem_q[3]);
    cmd_o.diff      = diff_q;
    cmd_o.depth     = depth_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Capture request, then walk key nibbles from the top
  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && accept_i) begin
      pk_q    <= pawn_key_i;
      mk_q    <= minor_key_i;
      last_q  <= last_move_i;
      ckey_q  <= cont_move_i ^ hash_w[15:0];
      mode_q  <= mode_i;
      side_q  <= side_i;
      diff_q  <= diff_i;
      depth_q <= depth_i;
      nib_q   <= 4'd15;
      for (int i = 0; i < 4; i++) begin
        rem_q[i] <= '0;
      end
    end else if (state_q == F_MOD) begin
      nib_q <= nib_q - 4'd1;
      for (int i = 0; i < 4; i++) begin
        rem_q[i] <= rem_d[i];
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/cht_div.sv
`timescale 1ns / 1ps
`default_nettype none
module cht_div (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic signed [cht_pkg::DIV_W-1:0] dividend_i,
  input  wire logic [cht_pkg::DVSR_W-1:0]      divisor_i,
  output logic                                 done_o,
  output logic signed [cht_pkg::DIV_W-1:0]     quot_o
);
  import cht_pkg::*;

  localparam int CW = $clog2(DIV_W);

  logic [DIV_W-1:0]  acc_q;
  logic [DVSR_W-1:0] rem_q;
  logic [CW-1:0]     cnt_q;
  logic              run_q, neg_q, done_q;
  logic [DVSR_W:0]   t_w, r_w;
  logic              ge_w;

  // One quotient bit per cycle
  assign t_w  = {rem_q, acc_q[DIV_W-1]};
  assign ge_w = (t_w >= {1'b0, divisor_i});
  assign r_w  = ge_w ? (t_w - {1'b0, divisor_i}) : t_w;

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed(acc_q) : $signed(acc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(DIV_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Divide magnitudes, sign applied on the way out
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DIV_W-1];
      acc_q <= dividend_i[DIV_W-1] ? DIV_W'(-dividend_i) : DIV_W'(dividend_i);
      rem_q <= '0;
    end else if (run_q) begin
      acc_q <= {acc_q[DIV_W-2:0], ge_w};
      rem_q <= r_w[DVSR_W-1:0];
    end
  end

endmodule
`default_nettype wire

>>> rtl/cht_back.sv
`timescale 1ns / 1ps
`default_nettype none
module cht_back #(
  parameter int TABLE_ENTRIES = 16384
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [10:0]   grain_i,
  input  wire logic [10:0]   depth_div_i,
  input  wire logic [13:0]   max_corr_i,
  input  wire cht_pkg::cmd_t cmd_i,
  input  wire logic          q_empty_i,
  output logic               pop_o,
  output logic               clearing_o,
  output logic               done_o,
  output logic [16:0]        correction_o
);
  import cht_pkg::*;

  localparam int SLOTS = 2 * TABLE_ENTRIES;
  localparam int AW    = $clog2(SLOTS);
  localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);
  localparam logic [AW-1:0] HALF_OFS  = AW'(TABLE_ENTRIES);

  back_state_e state_q, state_d;

  cmd_t               cmd_q;
  logic [AW-1:0]      clr_q;
  logic [AW-1:0]      addr_q [4];
  logic signed [15:0] ent_q  [4];
  logic signed [15:0] new_q  [4];
  logic [15:0]        rdata_w [4];
  logic [1:0]         k_q;
  logic signed [27:0] prod1_q;
  logic signed [31:0] prod2_q;
  logic signed [31:0] prode_q;
  logic signed [14:0] step_q;
  logic [16:0]        corr_q;

  logic [10:0]        g_w, dd_w;
  logic [13:0]        maxv_w;
  logic               div_start, div_done;
  logic signed [31:0] div_dividend, div_quot;
  logic [DVSR_W-1:0]  div_divisor;
  logic               ram_we;
  logic signed [17:0] sum_w;
  logic signed [33:0] p2_w;
  logic signed [30:0] pe_w;
  logic [13:0]        mag_w;
  logic signed [19:0] nv_w;
  logic signed [15:0] sat_w;
  logic signed [14:0] clamp_w;
  logic signed [31:0] maxs_w;
  logic [IDX_MAX_W-1:0] idx_w [4];

  // Zero registers act as one
  assign g_w    = (grain_i == 11'd0) ? 11'd1 : grain_i;
  assign dd_w   = (depth_div_i == 11'd0) ? 11'd1 : depth_div_i;
  assign maxv_w = (max_corr_i == 14'd0) ? 14'd1 : max_corr_i;

  assign idx_w[0] = cmd_q.idx_pawn;
  assign idx_w[1] = cmd_q.idx_minor;
  assign idx_w[2] = cmd_q.idx_last;
  assign idx_w[3] = cmd_q.idx_cont;

  // Datapath terms
  assign sum_w  = 18'(ent_q[0]) + 18'(ent_q[1]) + 18'(ent_q[2]) + 18'(ent_q[3]);
  assign p2_w   = prod1_q * $signed({1'b0, cmd_q.depth[7:3]});
  assign mag_w  = step_q[14] ? 14'(-step_q) : 14'(step_q);
  assign pe_w   = ent_q[k_q] * $signed({1'b0, mag_w});
  assign maxs_w = $signed({18'd0, maxv_w});
  assign nv_w   = 20'(ent_q[k_q]) + 20'(step_q) - div_quot[19:0];

  // Clamp the step and saturate the new entry
  always_comb begin
    if (div_quot > maxs_w) begin
      clamp_w = $signed({1'b0, maxv_w});
    end else if (div_quot < -maxs_w) begin
      clamp_w = -$signed({1'b0, maxv_w});
    end else begin
      clamp_w = div_quot[14:0];
    end
    if (nv_w > 20'sd32767) begin
      sat_w = 16'sh7fff;
    end else if (nv_w < -20'sd32768) begin
      sat_w = 16'sh8000;
    end else begin
      sat_w = nv_w[15:0];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_CLEAR:  if (clr_q == LAST_SLOT) state_d = B_IDLE;
      B_IDLE:   if (!q_empty_i) state_d = B_ADDR;
      B_ADDR:   state_d = B_READ;
      B_READ:   state_d = B_LATCH;
      B_LATCH:  state_d = (cmd_q.mode == MODE_UPDATE) ? B_MUL1 : B_SUM;
      B_SUM:    state_d = B_PDIV;
      B_PDIV:   if (div_done) state_d = B_OUT;
      B_OUT:    state_d = B_IDLE;
      B_MUL1:   state_d = B_MUL2;
      B_MUL2:   state_d = B_SDIVST;
      B_SDIVST: state_d = B_SDIV;
      B_SDIV:   if (div_done) state_d = B_CLAMP;
      B_CLAMP:  state_d = B_EMUL;
      B_EMUL:   state_d = B_EDIVST;
      B_EDIVST: state_d = B_EDIV;
      B_EDIV: begin
        if (div_done) begin
          state_d = (k_q == 2'd3) ? B_IDLE : B_EMUL;
        end
      end
      default:  state_d = B_IDLE;
    endcase
  end

  // Outputs and unit controls
  always_comb begin
    pop_o        = (state_q == B_IDLE) && !q_empty_i;
    clearing_o   = (state_q == B_CLEAR);
    done_o       = (state_q == B_OUT);
    correction_o = corr_q;
    div_start    = (state_q == B_SUM) || (state_q == B_SDIVST) || (state_q == B_EDIVST);
    ram_we       = (state_q == B_CLEAR) || ((state_q == B_EDIV) && div_done && (k_q == 2'd3));
    unique case (state_q)
      B_SUM:    div_dividend = 32'(sum_w);
      B_SDIVST: div_dividend = prod2_q;
      default:  div_dividend = prode_q;
    endcase
    unique case (state_q)
      B_SUM, B_PDIV:    div_divisor = DVSR_W'(g_w);
      B_SDIVST, B_SDIV: div_divisor = DVSR_W'(dd_w);
      default:          div_divisor = maxv_w;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == B_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      B_IDLE: begin
        cmd_q <= cmd_i;
      end
      B_ADDR: begin
        for (int i = 0; i < 4; i++) begin
          addr_q[i] <= cmd_q.side ? (HALF_OFS + AW'(idx_w[i])) : AW'(idx_w[i]);
        end
      end
      B_LATCH: begin
        for (int i = 0; i < 4; i++) begin
          ent_q[i] <= $signed(rdata_w[i]);
        end
        k_q <= 2'd0;
      end
      B_PDIV: begin
        corr_q <= div_quot[16:0];
      end
      B_MUL1: begin
        prod1_q <= cmd_q.diff * $signed({1'b0, g_w});
      end
      B_MUL2: begin
        prod2_q <= p2_w[31:0];
      end
      B_SDIV: begin
        step_q <= clamp_w;
      end
      B_EMUL: begin
        prode_q <= 32'(pe_w);
      end
      B_EDIV: begin
        if (div_done) begin
          new_q[k_q] <= sat_w;
          k_q        <= k_q + 2'd1;
        end
      end
      default: begin
        k_q <= k_q;
      end
    endcase
  end

  cht_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Four tables; the last entry of an update is written straight from the saturator
  for (genvar i = 0; i < 4; i++) begin : g_tbl
    logic [AW-1:0] waddr;
    logic [15:0]   wdata;
    assign waddr = clearing_o ? clr_q : addr_q[i];
    assign wdata = clearing_o ? 16'd0 : ((i == 3) ? sat_w : new_q[i]);
    cht_ram #(
      .WIDTH (16),
      .DEPTH (SLOTS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we),
      .waddr_i (waddr),
      .wdata_i (wdata),
      .raddr_i (addr_q[i]),
      .rdata_o (rdata_w[i])
    );
  end

endmodule
`default_nettype wire

>>> rtl/correction_history_tables_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Correction history tables: four signed 16-bit tables (pawn key, minor key,
// last move, continuation) split by side to move.
// Request channel: a request is taken at a rising edge with start high and
// busy low. mode 0 probes the tables, mode 1 updates them.
// Result channel: a probe yields one correction on correction_o, marked by
// done_o for exactly one cycle; the receiver cannot stall it. An update
// yields no result.
// Timing: the front reduces all four keys modulo TABLE_ENTRIES four key bits
// per cycle, then hands the request through a two-entry queue to the back.
// The back runs one shared 32-step divider: a probe does one division, an
// update one step division plus one per table. Busy drops once the front has
// pushed the request into the queue, so the front classifies the next request
// while the back still works.
// Reset: all tables are cleared by a pass over all 2*TABLE_ENTRIES slots,
// during which busy stays high; configuration writes are taken throughout.
// Registers (APB, byte address 4*i): grain, depth_divisor, max_correction.
module correction_history_tables_top #(
  parameter int TABLE_ENTRIES = 16384
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        mode_i,
  input  wire logic [63:0] pawn_key_i,
  input  wire logic [63:0] minor_key_i,
  input  wire logic [15:0] last_move_i,
  input  wire logic [15:0] cont_move_i,
  input  wire logic        side_i,
  input  wire logic [15:0] diff_i,
  input  wire logic [7:0]  depth_i,
  output logic             done_o,
  output logic [16:0]      correction_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import cht_pkg::*;

  logic [10:0] grain_q, depth_div_q;
  logic [13:0] max_corr_q;
  logic        wr_en, front_busy, clearing, push, pop, q_full, q_empty;
  cmd_t        front_cmd, back_cmd;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign busy   = front_busy || clearing;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grain_q     <= GRAIN_RST;
      depth_div_q <= DEPTH_DIV_RST;
      max_corr_q  <= MAX_CORR_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_GRAIN:     grain_q     <= pwdata[10:0];
        REG_DEPTH_DIV: depth_div_q <= pwdata[10:0];
        REG_MAX_CORR:  max_corr_q  <= pwdata[13:0];
        default:       grain_q     <= grain_q;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (paddr[3:2])
      REG_GRAIN:     prdata = {21'd0, grain_q};
      REG_DEPTH_DIV: prdata = {21'd0, depth_div_q};
      REG_MAX_CORR:  prdata = {18'd0, max_corr_q};
      default:       prdata = 32'd0;
    endcase
  end

  cht_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (start && !busy),
    .mode_i      (mode_i),
    .pawn_key_i  (pawn_key_i),
    .minor_key_i (minor_key_i),
    .last_move_i (last_move_i),
    .cont_move_i (cont_move_i),
    .side_i      (side_i),
    .diff_i      (diff_i),
    .depth_i     (depth_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .cmd_o       (front_cmd),
    .busy_o      (front_busy)
  );

  cht_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_cmd),
    .pop_i   (pop),
    .rdata_o (back_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  cht_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .grain_i      (grain_q),
    .depth_div_i  (depth_div_q),
    .max_corr_i   (max_corr_q),
    .cmd_i        (back_cmd),
    .q_empty_i    (q_empty),
    .pop_o        (pop),
    .clearing_o   (clearing),
    .done_o       (done_o),
    .correction_o (correction_o)
  );

endmodule
`default_nettype wire

>>> tb/sv/correction_history_tables_top_tb.sv
`timescale 1ns / 1ps
module correction_history_tables_top_tb;
  import cht_pkg::*;

  localparam int          ENTRIES      = 16384;
  localparam int          LIMIT_CYCLES = 4000000;
  localparam int          DRAIN_CYCLES = 800;
  localparam int          PHASE_ITEMS  = 300;
  localparam logic [3:0]  ADDR_UNUSED  = 4'd12;

  // Correction table predictor and store of expected corrections
  class correction_board;
    shortint     tab[4][2*ENTRIES];
    int unsigned grain_q;
    int unsigned ddiv_q;
    int unsigned maxc_q;
    logic [16:0] want_q[$];

    function new();
      grain_q = GRAIN_RST;
      ddiv_q  = DEPTH_DIV_RST;
      maxc_q  = MAX_CORR_RST;
    endfunction

    function void set_config(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_GRAIN:     grain_q = val[10:0];
        REG_DEPTH_DIV: ddiv_q  = val[10:0];
        REG_MAX_CORR:  maxc_q  = val[13:0];
        default: ;
      endcase
    endfunction

    function int slot(longint unsigned key, bit side);
      longint unsigned n;
      n = ENTRIES;
      return int'(side) * ENTRIES + int'(key % n);
    endfunction

    // Note one accepted request: probe queues a correction, update nudges entries
    function void note_request(bit mode, logic [63:0] pk, logic [63:0] mk,
                               logic [15:0] lm, logic [15:0] cm, bit side,
                               logic signed [15:0] diff, logic [7:0] depth);
      logic [31:0] prod;
      logic [15:0] ckey;
      int          idx[4];
      longint      g, dd, mx, sum, corr, bonus, step, dep, dl, mag, cur, nv;
      prod = {16'b0, lm} * {16'b0, CKEY_MULT};
      ckey = cm ^ prod[15:0];
      idx[0] = slot(pk, side);
      idx[1] = slot(mk, side);
      idx[2] = slot({48'b0, lm}, side);
      idx[3] = slot({48'b0, ckey}, side);
      g  = (grain_q == 0) ? 1 : grain_q;
      dd = (ddiv_q == 0) ? 1 : ddiv_q;
      mx = (maxc_q == 0) ? 1 : maxc_q;
      if (mode == MODE_PROBE) begin
        sum = 0;
        for (int t = 0; t < 4; t++) sum += tab[t][idx[t]];
        corr = sum / g;
        want_q.push_back(corr[16:0]);
      end else begin
        dl = diff;
        dep = depth;
        bonus = dl * g;
        step = (bonus * (dep / 8)) / dd;
        if (step > mx) step = mx;
        if (step < -mx) step = -mx;
        mag = (step < 0) ? -step : step;
        for (int t = 0; t < 4; t++) begin
          cur = tab[t][idx[t]];
          nv = cur + step - (cur * mag) / mx;
          if (nv > 32767) nv = 32767;
          if (nv < -32768) nv = -32768;
          tab[t][idx[t]] = shortint'(nv);
        end
      end
    endfunction

    // Compare one correction with the oldest expectation; empty string if fine
    function string check_correction(logic [16:0] got);
      logic [16:0] want;
      if (want_q.size() == 0) return $sformatf("correction %h with none expected", got);
      want = want_q.pop_front();
      if (got !== want) return $sformatf("correction %h, expected %h", got, want);
      return "";
    endfunction

    function int pending();
      return want_q.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        mode_i;
  logic [63:0] pawn_key_i;
  logic [63:0] minor_key_i;
  logic [15:0] last_move_i;
  logic [15:0] cont_move_i;
  logic        side_i;
  logic [15:0] diff_i;
  logic [7:0]  depth_i;
  logic        done_o;
  logic [16:0] correction_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  correction_board board = new();
  int          mismatches = 0;
  int          cycles = 0;
  int          idle_pct = 37;
  logic [63:0] key_pool[8];
  logic [15:0] move_pool[8];

  correction_history_tables_top #(.TABLE_ENTRIES(ENTRIES)) u_top (
    .clk_i, .rst_ni, .start, .busy, .mode_i, .pawn_key_i, .minor_key_i,
    .last_move_i, .cont_move_i, .side_i, .diff_i, .depth_i, .done_o,
    .correction_o, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  // Check every correction on its strobe
  always @(posedge clk_i) begin
    string msg;
    if (rst_ni && done_o) begin
      msg = board.check_correction(correction_o);
      if (msg != "") report_mismatch(msg);
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("[correction_history_tables_top] ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [3:0] addr, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (pready) break;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr[3:2] != 2'd3) board.set_config(addr[3:2], val);
  endtask

  // Send one request, hold until taken, then maybe idle
  task automatic send_request(bit mode, logic [63:0] pk, logic [63:0] mk,
                              logic [15:0] lm, logic [15:0] cm, bit side,
                              logic [15:0] diff, logic [7:0] depth);
    start       <= 1'b1;
    mode_i      <= mode;
    pawn_key_i  <= pk;
    minor_key_i <= mk;
    last_move_i <= lm;
    cont_move_i <= cm;
    side_i      <= side;
    diff_i      <= diff;
    depth_i     <= depth;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    board.note_request(mode, pk, mk, lm, cm, side, diff, depth);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Drain results, then let the back end finish any update
  task automatic settle();
    start <= 1'b0;
    while (board.pending() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [63:0] pick_key();
    if ($urandom_range(9) == 0) return {$urandom, $urandom};
    return key_pool[$urandom_range(7)];
  endfunction

  function automatic logic [15:0] pick_move();
    if ($urandom_range(9) == 0) return 16'($urandom);
    return move_pool[$urandom_range(7)];
  endfunction

  task automatic send_random();
    bit          mode;
    logic [15:0] diff;
    logic [7:0]  depth;
    mode = ($urandom_range(99) < 45) ? MODE_PROBE : MODE_UPDATE;
    case ($urandom_range(9))
      0:       diff = 16'h7fff;
      1:       diff = 16'h8000;
      default: diff = 16'($urandom);
    endcase
    depth = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(8, 40));
    send_request(mode, pick_key(), pick_key(), pick_move(), pick_move(),
                 1'($urandom_range(1)), diff, depth);
  endtask

  task automatic run_phase(logic [31:0] g, logic [31:0] dd, logic [31:0] mx, int pct);
    write_reg({REG_GRAIN, 2'b00}, g);
    write_reg({REG_DEPTH_DIV, 2'b00}, dd);
    write_reg({REG_MAX_CORR, 2'b00}, mx);
    idle_pct = pct;
    repeat (PHASE_ITEMS) send_random();
    settle();
  endtask

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    mode_i      = MODE_PROBE;
    pawn_key_i  = '0;
    minor_key_i = '0;
    last_move_i = '0;
    cont_move_i = '0;
    side_i      = 1'b0;
    diff_i      = '0;
    depth_i     = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    move_pool[0] = '0;
    move_pool[1] = '1;
    for (int k = 2; k < 8; k++) begin
      key_pool[k]  = {$urandom, $urandom};
      move_pool[k] = 16'($urandom);
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: cleared tables, extreme errors and depths, both sides
    send_request(MODE_PROBE, '1, '1, '1, '1, 1'b1, '0, '0);
    send_request(MODE_UPDATE, '1, '1, '1, '1, 1'b1, 16'h7fff, 8'd255);
    send_request(MODE_PROBE, '1, '1, '1, '1, 1'b1, '0, '0);
    send_request(MODE_PROBE, '1, '1, '1, '1, 1'b0, '0, '0);
    send_request(MODE_UPDATE, '0, '0, '0, '0, 1'b0, 16'h8000, 8'd255);
    send_request(MODE_PROBE, '0, '0, '0, '0, 1'b0, '0, '0);
    send_request(MODE_UPDATE, '0, '0, '0, '0, 1'b0, 16'h0005, 8'd7);
    send_request(MODE_PROBE, '0, '0, '0, '0, 1'b0, '0, '0);
    send_request(MODE_UPDATE, '0, '0, '0, '0, 1'b0, 16'h0005, 8'd8);
    send_request(MODE_PROBE, '0, '0, '0, '0, 1'b0, '0, '0);
    send_request(MODE_UPDATE, 64'h4000, 64'h8001, 16'h1234, 16'hfedc, 1'b1,
                 16'hffff, 8'd16);
    send_request(MODE_PROBE, 64'h4000, 64'h8001, 16'h1234, 16'hfedc, 1'b1, '0, '0);
    settle();

    // Unmapped register address must leave settings alone
    write_reg(ADDR_UNUSED, 32'hffff_ffff);
    send_request(MODE_PROBE, '1, '1, '1, '1, 1'b1, '0, '0);
    settle();

    // Random phases over register extremes; one phase never idles
    run_phase(32'd1, 32'd1, 32'd1, 37);
    run_phase(32'd2047, 32'd2047, 32'd16383, 0);
    run_phase(32'd0, 32'd0, 32'd0, 37);
    run_phase(32'd1024, 32'd1, 32'd16383, 37);
    run_phase(32'd256, 32'd8, 32'd1024, 37);
    run_phase(32'($urandom_range(1, 1024)), 32'($urandom_range(1, 1024)),
              32'($urandom_range(1, 16383)), 37);

    if (mismatches == 0) begin
      $display("[correction_history_tables_top] OK");
    end else begin
      $display("[correction_history_tables_top] ERROR");
    end
    $finish;
  end

endmodule
